@@ rtl/argb_box_downsample_2x_unit_macros.svh @@
`ifndef ARGB_BOX_DOWNSAMPLE_2X_UNIT_MACROS_SVH
`define ARGB_BOX_DOWNSAMPLE_2X_UNIT_MACROS_SVH

// check a condition at every clock edge out of reset
`define ABD2X_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("abd2x assertion failed");

// check that a trigger is followed by a condition in the next cycle
`define ABD2X_ASSERT_NEXT(label, trig, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error("abd2x assertion failed");

`endif

@@ rtl/abd2x_pkg.sv @@
`default_nettype none

package abd2x_pkg;

  localparam int TEXEL_W = 32;
  localparam int CHAN_W = 8;
  localparam int CHANNELS = 4;
  localparam int SUM_W = CHAN_W + 1;
  localparam int PAIR_W = CHANNELS * SUM_W;
  localparam int CFG_W = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int MAX_WIDTH_DEFAULT = 1024;

  typedef logic [TEXEL_W-1:0] texel_t;
  typedef logic [PAIR_W-1:0] pair_t;
  typedef logic [CFG_W-1:0] size_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_SOURCE_WIDTH = 1'd0;
  localparam cfg_index_t REG_SOURCE_HEIGHT = 1'd1;

  localparam size_t SIZE_RESET = 11'd1024;
  localparam size_t HEIGHT_LIMIT = 11'd1024;

  function automatic pair_t pair_of(input texel_t a, input texel_t b);
    pair_t r;
    r = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      r[c*SUM_W +: SUM_W] = SUM_W'(a[c*CHAN_W +: CHAN_W]) + SUM_W'(b[c*CHAN_W +: CHAN_W]);
    end
    return r;
  endfunction

  function automatic texel_t average_of(input pair_t p, input pair_t q);
    texel_t r;
    logic [SUM_W:0] s;
    r = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      s = (SUM_W+1)'(p[c*SUM_W +: SUM_W]) + (SUM_W+1)'(q[c*SUM_W +: SUM_W]);
      r[c*CHAN_W +: CHAN_W] = s[SUM_W:2];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/abd2x_in_if.sv @@
`default_nettype none

interface abd2x_in_if import abd2x_pkg::*; ();
  logic valid;
  logic ready;
  texel_t texel_in;

  modport source(output valid, output texel_in, input ready);
  modport sink(input valid, input texel_in, output ready);
endinterface

`default_nettype wire

@@ rtl/abd2x_out_if.sv @@
`default_nettype none

interface abd2x_out_if import abd2x_pkg::*; ();
  logic valid;
  logic ready;
  texel_t texel_out;
  logic end_of_row;
  logic end_of_frame;

  modport source(output valid, output texel_out, output end_of_row, output end_of_frame,
                 input ready);
  modport sink(input valid, input texel_out, input end_of_row, input end_of_frame,
               output ready);
endinterface

`default_nettype wire

@@ rtl/abd2x_ram.sv @@
`default_nettype none

module abd2x_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 512,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/argb_box_downsample_2x_unit.sv @@
// 2x2 box-filter downsampler for ARGB8888 texels. Source texels enter one per clock, unless
// the output is back-pressured, in row-major order and the half-size image leaves in
// row-major order, each channel the truncated mean of its 2x2 block. The block takes one
// texel per cycle with no stalls of its own; a result passes through the s1 stage and the
// output register after the texel that completes its block. Pair sums of each upper row
// wait in a single-port-write, single-port-read line memory of MAX_WIDTH/2 entries; a
// lower-row texel reads its entry in the accept cycle and the sum is finished in the next
// stage. The memory needs no clearing after reset. Writing either size register restarts
// the frame; write them only while the block is idle.
`default_nettype none
`include "argb_box_downsample_2x_unit_macros.svh"

module argb_box_downsample_2x_unit import abd2x_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  cfg_index_t cfg_index,
  input  size_t      cfg_data,
  abd2x_in_if.sink   up,
  abd2x_out_if.source down
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  size_t source_width;
  size_t source_height;
  size_t column_count;
  size_t row_count;
  texel_t held_left_texel;

  logic s1_valid;
  pair_t s1_pair;
  logic s1_self;
  logic s1_eor;
  logic s1_eof;

  logic out_valid;
  texel_t out_texel;
  logic out_eor;
  logic out_eof;

  size_t w, h, dw, dh, w_even, h_even, px, oy;
  logic w_one, h_one;
  logic accept, col_in_pair, have_pair, upper, lower, emit;
  logic line_we, line_re, eor, eof;
  logic out_free;
  pair_t pair;
  pair_t line_rdata;

  always_comb begin
    if (source_width == '0) begin
      w = size_t'(1);
    end else if (int'(source_width) > MAX_WIDTH) begin
      w = size_t'(MAX_WIDTH);
    end else begin
      w = source_width;
    end
    if (source_height == '0) begin
      h = size_t'(1);
    end else if (source_height > HEIGHT_LIMIT) begin
      h = HEIGHT_LIMIT;
    end else begin
      h = source_height;
    end
  end

  assign w_one = (w == size_t'(1));
  assign h_one = (h == size_t'(1));
  assign dw = w_one ? size_t'(1) : (w >> 1);
  assign dh = h_one ? size_t'(1) : (h >> 1);
  assign w_even = {w[CFG_W-1:1], 1'b0};
  assign h_even = {h[CFG_W-1:1], 1'b0};

  assign out_free = !out_valid || down.ready;
  assign up.ready = !s1_valid || out_free;
  assign accept = up.valid && up.ready;

  assign col_in_pair = !w_one && (column_count < w_even);
  assign have_pair = w_one || (col_in_pair && column_count[0]);
  assign px = w_one ? '0 : (column_count >> 1);
  assign pair = pair_of(w_one ? up.texel_in : held_left_texel, up.texel_in);

  assign upper = !h_one && (row_count < h_even) && !row_count[0];
  assign lower = !h_one && (row_count < h_even) && row_count[0];
  assign emit = have_pair && (h_one || lower);
  assign oy = h_one ? '0 : (row_count >> 1);
  assign eor = (px == dw - size_t'(1));
  assign eof = eor && (oy == dh - size_t'(1));

  assign line_we = accept && have_pair && upper;
  assign line_re = accept && have_pair && lower;

  abd2x_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(LINE_DEPTH),
    .AW   (AW)
  ) u_line (
    .clk  (clk),
    .we   (line_we),
    .waddr(AW'(px)),
    .wdata(pair),
    .re   (line_re),
    .raddr(AW'(px)),
    .rdata(line_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width <= SIZE_RESET;
      source_height <= SIZE_RESET;
      column_count <= '0;
      row_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_WIDTH: begin
          source_width <= cfg_data;
          column_count <= '0;
          row_count <= '0;
        end
        REG_SOURCE_HEIGHT: begin
          source_height <= cfg_data;
          column_count <= '0;
          row_count <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (column_count == w - size_t'(1)) begin
        column_count <= '0;
        row_count <= (row_count == h - size_t'(1)) ? '0 : row_count + size_t'(1);
      end else begin
        column_count <= column_count + size_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && col_in_pair && !column_count[0]) begin
      held_left_texel <= up.texel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= emit;
    end else if (s1_valid && out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_pair <= pair;
      s1_self <= h_one;
      s1_eor <= eor;
      s1_eof <= eof;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_texel <= average_of(s1_pair, s1_self ? s1_pair : line_rdata);
      out_eor <= s1_eor;
      out_eof <= s1_eof;
    end
  end

  assign down.valid = out_valid;
  assign down.texel_out = out_texel;
  assign down.end_of_row = out_eor;
  assign down.end_of_frame = out_eof;

  `ABD2X_ASSERT_ALWAYS(frame_end_on_row_end, !(out_valid && out_eof) || out_eor)
  `ABD2X_ASSERT_ALWAYS(position_in_frame, (column_count < w) && (row_count < h))
  `ABD2X_ASSERT_NEXT(line_read_has_stage, line_re, s1_valid && !s1_self)

endmodule

`default_nettype wire

@@ tb/sv/tb_argb_box_downsample_2x_unit.sv @@
`timescale 1ns / 1ps

module tb_argb_box_downsample_2x_unit import abd2x_pkg::*; ();

  localparam int RANDOM_ITEMS = 120;
  localparam int CALM_ITEMS = 40;
  localparam int PRESSURE_ITEMS = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LINE_DEPTH = MAX_WIDTH_DEFAULT / 2;

  typedef struct {
    texel_t texel;
    logic   eor;
    logic   eof;
  } average_word_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  size_t      cfg_data;

  abd2x_in_if  up_if ();
  abd2x_out_if down_if ();

  argb_box_downsample_2x_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .up        (up_if),
    .down      (down_if)
  );

  average_word_t pending_averages[$];
  int            errors = 0;
  int            cycle_count = 0;
  bit            in_gaps = 1'b0;
  bit            out_gaps = 1'b0;
  int            hold_left = 0;

  size_t       width_reg;
  size_t       height_reg;
  pair_t       upper_pair_sums [LINE_DEPTH];
  texel_t      left_texel;
  int unsigned col_pos;
  int unsigned row_pos;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned clamp_size(input size_t v, input int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic pair_t sum_pair(input texel_t a, input texel_t b);
    pair_t p;
    p = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      p[c*SUM_W +: SUM_W] = SUM_W'(a[c*CHAN_W +: CHAN_W]) + SUM_W'(b[c*CHAN_W +: CHAN_W]);
    end
    return p;
  endfunction

  function automatic texel_t block_mean(input pair_t upper, input pair_t lower);
    texel_t m;
    int     total;
    m = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      total = int'(upper[c*SUM_W +: SUM_W]) + int'(lower[c*SUM_W +: SUM_W]);
      m[c*CHAN_W +: CHAN_W] = CHAN_W'(total / 4);
    end
    return m;
  endfunction

  task automatic predict_average(input texel_t t);
    int unsigned   w, h, dw, dh, x, y, px, oy;
    pair_t         pair;
    bit            have_pair, emit;
    texel_t        mean;
    average_word_t word;
    w = clamp_size(width_reg, MAX_WIDTH_DEFAULT);
    h = clamp_size(height_reg, HEIGHT_LIMIT);
    dw = (w > 1) ? w / 2 : 1;
    dh = (h > 1) ? h / 2 : 1;
    x = (col_pos < w) ? col_pos : 0;
    y = (row_pos < h) ? row_pos : 0;
    have_pair = 1'b0;
    emit = 1'b0;
    px = 0;
    oy = 0;
    mean = '0;
    pair = '0;
    if (w == 1) begin
      pair = sum_pair(t, t);
      have_pair = 1'b1;
    end else if (x < 2 * dw) begin
      if (x[0] == 1'b0) begin
        left_texel = t;
      end else begin
        pair = sum_pair(left_texel, t);
        have_pair = 1'b1;
        px = x / 2;
      end
    end
    if (have_pair && px < LINE_DEPTH) begin
      if (h == 1) begin
        mean = block_mean(pair, pair);
        emit = 1'b1;
      end else if (y < 2 * dh) begin
        if (y[0] == 1'b0) begin
          upper_pair_sums[px] = pair;
        end else begin
          mean = block_mean(upper_pair_sums[px], pair);
          oy = y / 2;
          emit = 1'b1;
        end
      end
    end
    if (emit) begin
      word.texel = mean;
      word.eor = (px == dw - 1);
      word.eof = (px == dw - 1) && (oy == dh - 1);
      pending_averages = {pending_averages, word};
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_pos = x;
    row_pos = y;
  endtask

  always @(posedge clk) begin
    average_word_t want;
    if (!rst && down_if.valid && down_if.ready) begin
      if (pending_averages.size() == 0) begin
        $error("unexpected word: texel_out %h", down_if.texel_out);
        errors++;
      end else begin
        want = pending_averages.pop_front();
        if (down_if.texel_out !== want.texel) begin
          $error("texel_out: expected %h, got %h", want.texel, down_if.texel_out);
          errors++;
        end
        if (down_if.end_of_row !== want.eor) begin
          $error("end_of_row: expected %b, got %b", want.eor, down_if.end_of_row);
          errors++;
        end
        if (down_if.end_of_frame !== want.eof) begin
          $error("end_of_frame: expected %b, got %b", want.eof, down_if.end_of_frame);
          errors++;
        end
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    down_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        down_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        down_if.ready <= 1'b0;
        stall_left--;
      end else if (out_gaps && $urandom_range(0, 5) == 0) begin
        down_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        down_if.ready <= 1'b1;
      end
    end
  end

  function automatic texel_t random_texel();
    texel_t t;
    t = $urandom();
    if ($urandom_range(0, 4) == 0) begin
      for (int c = 0; c < CHANNELS; c++) begin
        t[c*CHAN_W +: CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
    end
    return t;
  endfunction

  task automatic send_texel(input texel_t t);
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      up_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    up_if.valid <= 1'b1;
    up_if.texel_in <= t;
    @(posedge clk);
    while (!up_if.ready) @(posedge clk);
    predict_average(t);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_texel(random_texel());
  endtask

  task automatic wait_idle();
    up_if.valid <= 1'b0;
    while (pending_averages.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input size_t value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SOURCE_WIDTH) width_reg = value;
    else height_reg = value;
    col_pos = 0;
    row_pos = 0;
    @(negedge clk);
  endtask

  task automatic set_size(input size_t w, input size_t h);
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
  endtask

  task automatic test_channel_extremes();
    wait_idle();
    set_size(11'd4, 11'd2);
    send_texel(32'hFFFF_FFFF);
    send_texel(32'hFFFF_FFFF);
    send_texel(32'h0000_0000);
    send_texel(32'h0102_0304);
    send_texel(32'hFFFF_FFFF);
    send_texel(32'hFFFF_FFFF);
    send_texel(32'h0303_0303);
    send_texel(32'hFF00_FF00);
  endtask

  task automatic test_single_axis();
    wait_idle();
    set_size(11'd1, 11'd1);
    send_texel(32'h8040_2010);
    send_texel(32'hFFFF_FFFF);
    wait_idle();
    set_size(11'd1, 11'd3);
    send_random(3);
    wait_idle();
    set_size(11'd3, 11'd1);
    send_random(3);
    wait_idle();
    set_size(11'd0, 11'd0);
    send_texel(32'h00FF_00FF);
  endtask

  task automatic test_odd_sizes();
    wait_idle();
    set_size(11'd3, 11'd3);
    send_random(9);
  endtask

  task automatic test_size_saturation();
    wait_idle();
    set_size(11'd2047, 11'd1);
    send_random(MAX_WIDTH_DEFAULT);
  endtask

  task automatic test_restart_mid_frame();
    wait_idle();
    set_size(11'd6, 11'd4);
    send_random(10);
    wait_idle();
    write_reg(REG_SOURCE_HEIGHT, 11'd4);
    send_random(24);
    send_random(7);
    wait_idle();
    write_reg(REG_SOURCE_WIDTH, 11'd2);
    send_random(8);
  endtask

  task automatic test_back_pressure();
    wait_idle();
    set_size(11'd8, 11'd4);
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    hold_left = HOLD_CYCLES;
    send_random(PRESSURE_ITEMS);
    wait_idle();
    send_random(PRESSURE_ITEMS);
  endtask

  task automatic test_random_frames();
    int    sent, n;
    size_t w, h;
    int    wc, hc;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) begin
        in_gaps = 1'b0;
        out_gaps = 1'b0;
      end else begin
        in_gaps = $urandom_range(0, 3) != 0;
        out_gaps = $urandom_range(0, 3) != 0;
      end
      w = size_t'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 12));
      h = size_t'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) : $urandom_range(1, 8));
      set_size(w, h);
      wc = (w == 0) ? 1 : w;
      hc = (h == 0) ? 1 : h;
      n = $urandom_range(1, 3) * wc * hc;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      send_random(n);
      sent += n;
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_SOURCE_WIDTH;
    cfg_data <= '0;
    up_if.valid <= 1'b0;
    up_if.texel_in <= '0;
    width_reg = SIZE_RESET;
    height_reg = SIZE_RESET;
    left_texel = '0;
    col_pos = 0;
    row_pos = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    test_channel_extremes();
    test_single_axis();
    test_odd_sizes();
    test_restart_mid_frame();
    test_size_saturation();
    test_back_pressure();
    test_random_frames();
    wait_idle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
